### rtl/io_interrupt_redirection_controller_unit_macros.svh
// Assertion macros shared by the RTL.
`ifndef IO_INTERRUPT_REDIRECTION_CONTROLLER_UNIT_MACROS_SVH
`define IO_INTERRUPT_REDIRECTION_CONTROLLER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define IRC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define IRC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define IRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/irc_pkg.sv
package irc_pkg;
  localparam int NUM_LINES = 24;
  localparam int LINE_W = 5;

  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_ASSERT = 3'd2;
  localparam logic [2:0] REQ_PULSE  = 3'd3;
  localparam logic [2:0] REQ_DEASRT = 3'd4;
  localparam logic [2:0] REQ_EOI    = 3'd5;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_EXT  = 2'd2;

  localparam logic [7:0] OFF_INDEX = 8'h00;
  localparam logic [7:0] OFF_DATA  = 8'h10;
  localparam logic [7:0] OFF_PIN   = 8'h20;
  localparam logic [7:0] OFF_EOI   = 8'h40;

  localparam logic [1:0] CFG_EXT_MODE = 2'd0;
  localparam logic [1:0] CFG_APIC_ID  = 2'd1;

  localparam logic [2:0] DM_SMI    = 3'd2;
  localparam logic [2:0] DM_NMI    = 3'd4;
  localparam logic [2:0] DM_INIT   = 3'd5;
  localparam logic [2:0] DM_EXTINT = 3'd7;

  // Commands handed from the front end to the scan engine.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_SCAN  = 2'd1,
    OP_ONE   = 2'd2,
    OP_EOI   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [LINE_W-1:0] line;
    logic [7:0]       vec;
    logic             clr_after;
  } cmd_t;
endpackage

### rtl/irc_front.sv
// Decodes one transfer, updates registers and hands scans to the back end.
module irc_front import irc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [2:0]  req_type,
  input  logic [7:0]  reg_offset,
  input  logic [31:0] write_data,
  input  logic [4:0]  irq_line,
  input  logic [7:0]  eoi_vector,
  input  logic        ext_mode,
  input  logic [63:0] tbl_q [NUM_LINES],
  input  logic [NUM_LINES-1:0] lvl_q,
  output logic        rd_v,
  output logic [31:0] rd_data,
  output logic        tw_v,
  output logic [LINE_W-1:0] tw_line,
  output logic [63:0] tw_entry,
  output logic        lvl_set,
  output logic        lvl_clr,
  output logic        pend_set,
  output logic [LINE_W-1:0] ev_line,
  output cmd_t        cmd
);
  logic [7:0] index_r;
  logic [3:0] own_id_r;
  logic boot_r;
  logic [7:0] idx_nxt;
  logic [3:0] id_nxt;
  logic boot_nxt;
  logic [6:0] d;
  logic [LINE_W-1:0] ln, pl;
  logic tbl_idx;
  logic [63:0] old, e;
  logic raise, is_lvl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0; own_id_r <= 4'd2; boot_r <= 1'b0;
    end else begin
      index_r <= idx_nxt; own_id_r <= id_nxt; boot_r <= boot_nxt;
    end
  end

  always_comb begin
    idx_nxt = index_r; id_nxt = own_id_r; boot_nxt = boot_r;
    rd_v = 1'b0; rd_data = 32'hFFFF_FFFF;
    tw_v = 1'b0; lvl_set = 1'b0; lvl_clr = 1'b0; pend_set = 1'b0;
    cmd = '{op: OP_NONE, line: '0, vec: '0, clr_after: 1'b0};
    d = index_r[6:0] - 7'h10;
    tbl_idx = (index_r >= 8'h10) && (index_r < 8'(16 + 2 * NUM_LINES));
    tw_line = d[5:1];
    old = tbl_q[tbl_idx ? d[5:1] : '0];
    e = d[0] ? {write_data, old[31:0]} : {old[63:32], write_data};
    e[55:17] = '0;
    e[14] = e[15] & old[14];
    e[12] = old[12];
    tw_entry = e;
    raise = 1'b0; is_lvl = 1'b0;
    pl = write_data[4:0];
    ln = irq_line;
    if (go) begin
      case (req_type)
        REQ_READ: begin
          rd_v = 1'b1;
          if (reg_offset == OFF_INDEX) rd_data = {24'd0, index_r};
          else if (reg_offset == OFF_DATA) begin
            if (index_r == 8'd0) rd_data = {4'd0, own_id_r, 24'd0};
            else if (index_r == 8'd1)
              rd_data = {8'd0, 8'(NUM_LINES - 1), 8'd0, ext_mode ? 8'h20 : 8'h11};
            else if (index_r == 8'd2) rd_data = {4'd0, 4'd2, 24'd0};
            else if (index_r == 8'd3) rd_data = {31'd0, boot_r};
            else if (tbl_idx)
              rd_data = d[0] ? tbl_q[d[5:1]][63:32] : tbl_q[d[5:1]][31:0];
          end
        end
        REQ_WRITE: begin
          if (reg_offset == OFF_INDEX) idx_nxt = write_data[7:0];
          else if (reg_offset == OFF_PIN) begin
            if (ext_mode) begin raise = 1'b1; ln = pl; end
          end else if (reg_offset == OFF_EOI) begin
            if (ext_mode) cmd = '{op: OP_EOI, line: '0, vec: write_data[7:0],
                                  clr_after: 1'b0};
          end else if (reg_offset == OFF_DATA) begin
            if (index_r == 8'd0) id_nxt = write_data[27:24];
            else if (index_r == 8'd3) boot_nxt = write_data[0];
            else if (tbl_idx) begin
              tw_v = 1'b1;
              cmd = '{op: OP_ONE, line: d[5:1], vec: '0, clr_after: 1'b0};
            end
          end
        end
        REQ_ASSERT: begin raise = 1'b1; is_lvl = 1'b1; end
        REQ_PULSE:  raise = 1'b1;
        REQ_DEASRT: if (ln < LINE_W'(NUM_LINES)) lvl_clr = 1'b1;
        REQ_EOI: cmd = '{op: OP_EOI, line: '0, vec: eoi_vector, clr_after: 1'b0};
        default: ;
      endcase
      if (raise && ln < LINE_W'(NUM_LINES) && !(is_lvl && lvl_q[ln])) begin
        lvl_set = is_lvl;
        if (tbl_q[ln][16:15] == 2'b10) lvl_clr = is_lvl;
        else begin
          pend_set = 1'b1;
          cmd = '{op: OP_SCAN, line: ln, vec: '0, clr_after: !is_lvl};
        end
      end
    end
    ev_line = ln;
  end
endmodule

### rtl/irc_back.sv
// Scan engine: walks the table one line per cycle and emits deliveries.
module irc_back import irc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_v,
  input  cmd_t        cmd_in,
  input  logic [7:0]  apic_id,
  input  logic [63:0] tbl_q [NUM_LINES],
  input  logic [NUM_LINES-1:0] pend_q,
  output logic        busy,
  output logic        act,
  output logic [LINE_W-1:0] cur,
  output logic        set_rirr,
  output logic        clr_rirr,
  output logic        clr_pend,
  output logic        fin,
  output logic        hit,
  output logic [1:0]  kind,
  output logic [7:0]  vec,
  output logic [2:0]  dm,
  output logic        trig
);
  cmd_t cmd_r, cmd_nxt;
  logic [LINE_W-1:0] cur_r, cur_nxt;
  logic act_r, act_nxt;
  logic [63:0] e;
  logic sel, pending, lvl, match, stop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0; cur_r <= '0; cmd_r <= '{op: OP_NONE, line: '0, vec: '0, clr_after: 1'b0};
    end else begin
      act_r <= act_nxt; cur_r <= cur_nxt; cmd_r <= cmd_nxt;
    end
  end

  assign busy = act_r;
  assign act = act_r;
  assign cur = cur_r;

  always_comb begin
    e = tbl_q[cur_r];
    sel = 1'b0;
    case (cmd_r.op)
      OP_SCAN: sel = 1'b1;
      OP_ONE:  sel = (cur_r == cmd_r.line);
      OP_EOI:  sel = (e[7:0] == cmd_r.vec) && e[14];
      default: sel = 1'b0;
    endcase
    clr_rirr = act_r && cmd_r.op == OP_EOI && sel;
    pending = pend_q[cur_r] && !e[16];
    dm = e[10:8];
    lvl = e[15] && !(dm == DM_SMI || dm == DM_NMI || dm == DM_INIT);
    trig = lvl;
    set_rirr = act_r && sel && pending && lvl;
    clr_pend = act_r && sel && pending && !lvl;
    // An EOI'd entry was just cleared, so its old remote IRR does not block.
    match = e[11] ? (apic_id < 8'd8 && e[56 + apic_id[2:0]])
                  : (e[59:56] == apic_id[3:0]);
    hit = act_r && sel && pending && !(lvl && e[14] && cmd_r.op != OP_EOI)
          && (dm == DM_EXTINT || match);
    kind = (dm == DM_EXTINT) ? KIND_EXT : KIND_INT;
    vec = (dm == DM_EXTINT) ? 8'd0 : e[7:0];
    stop = (cur_r == LINE_W'(NUM_LINES - 1));
    fin = act_r && stop;
    act_nxt = act_r; cur_nxt = cur_r; cmd_nxt = cmd_r;
    if (act_r) begin
      cur_nxt = cur_r + LINE_W'(1);
      if (stop) act_nxt = 1'b0;
    end else if (cmd_v) begin
      act_nxt = 1'b1; cur_nxt = '0; cmd_nxt = cmd_in;
    end
  end
endmodule

### rtl/io_interrupt_redirection_controller_unit.sv
// Register reads answer in the cycle after start with one strobed result.
// Table writes, pin or EOI register writes in extended mode, and line events
// that start a scan walk all 24 table entries, one per cycle, keeping busy
// high until the walk and any held delivery are done; deliveries come out in
// line order with one strobe each.
// Other items need no walk. The receiver cannot stall the result strobe.
// The last result of an item carries out_last; an item may give none.
`include "io_interrupt_redirection_controller_unit_macros.svh"
module io_interrupt_redirection_controller_unit import irc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_reg_offset,
  input  logic [31:0] in_write_data,
  input  logic [4:0]  in_irq_line,
  input  logic [7:0]  in_eoi_vector,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_read_data,
  output logic [7:0]  out_int_vector,
  output logic [2:0]  out_delivery_mode,
  output logic        out_trigger_mode,
  output logic        out_last
);
  logic ext_r;
  logic [7:0] apic_r;
  logic [63:0] tbl_r [NUM_LINES];
  logic [NUM_LINES-1:0] pend_r, lvl_r;
  logic go, bk_busy;
  logic rd_v, tw_v, lvl_set, lvl_clr, pend_set;
  logic [31:0] rd_data;
  logic [LINE_W-1:0] tw_line, ev_line;
  logic [63:0] tw_entry;
  cmd_t cmd, cmd_q;
  logic act, set_rirr, clr_rirr, clr_pend, fin, hit, trig;
  logic [LINE_W-1:0] cur;
  logic [1:0] kind;
  logic [7:0] vec;
  logic [2:0] dm;
  logic hold_v_r, hold_v_nxt;
  logic [1:0] hold_kind_r;
  logic [7:0] hold_vec_r;
  logic [2:0] hold_dm_r;
  logic hold_trig_r;
  logic [31:0] rd_r;
  logic rdv_r;

  assign go = start && !busy;
  assign busy = bk_busy || (cmd_q.op != OP_NONE) || hold_v_r;

  irc_front u_front (
    .clk, .rst_n, .go, .req_type(in_req_type), .reg_offset(in_reg_offset),
    .write_data(in_write_data), .irq_line(in_irq_line), .eoi_vector(in_eoi_vector),
    .ext_mode(ext_r), .tbl_q(tbl_r), .lvl_q(lvl_r),
    .rd_v, .rd_data, .tw_v, .tw_line, .tw_entry, .lvl_set, .lvl_clr, .pend_set,
    .ev_line, .cmd);

  irc_back u_back (
    .clk, .rst_n, .cmd_v(cmd_q.op != OP_NONE), .cmd_in(cmd_q), .apic_id(apic_r),
    .tbl_q(tbl_r), .pend_q(pend_r), .busy(bk_busy), .act, .cur, .set_rirr,
    .clr_rirr, .clr_pend, .fin, .hit, .kind, .vec, .dm, .trig);

  logic [LINE_W-1:0] scan_line_r;
  logic clr_after_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= 1'b0; apic_r <= '0; pend_r <= '0; lvl_r <= '0;
      cmd_q <= '{op: OP_NONE, line: '0, vec: '0, clr_after: 1'b0};
      hold_v_r <= 1'b0; rdv_r <= 1'b0;
      clr_after_r <= 1'b0; scan_line_r <= '0;
      for (int i = 0; i < NUM_LINES; i++) tbl_r[i] <= 64'h1_0000;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_EXT_MODE[0]) ext_r <= cfg_data[0];
        else apic_r <= cfg_data;
      end
      rdv_r <= rd_v; rd_r <= rd_data;
      if (tw_v) tbl_r[tw_line] <= tw_entry;
      if (lvl_set) lvl_r[ev_line] <= 1'b1;
      if (lvl_clr) begin lvl_r[ev_line] <= 1'b0; pend_r[ev_line] <= 1'b0; end
      if (pend_set) pend_r[ev_line] <= 1'b1;
      if (cmd_q.op != OP_NONE && !bk_busy) begin
        cmd_q <= '{op: OP_NONE, line: '0, vec: '0, clr_after: 1'b0};
        clr_after_r <= cmd_q.clr_after; scan_line_r <= cmd_q.line;
      end else if (cmd.op != OP_NONE) cmd_q <= cmd;
      // An EOI clears remote IRR first; a level recheck may set it again.
      if (clr_rirr) tbl_r[cur][14] <= 1'b0;
      if (set_rirr) tbl_r[cur][14] <= 1'b1;
      if (clr_pend) pend_r[cur] <= 1'b0;
      if (fin && clr_after_r) begin
        pend_r[scan_line_r] <= 1'b0;
        lvl_r[scan_line_r] <= 1'b0;
        clr_after_r <= 1'b0;
      end
      hold_v_r <= hold_v_nxt;
      if (hit) begin
        hold_kind_r <= kind; hold_vec_r <= vec; hold_dm_r <= dm;
        hold_trig_r <= trig;
      end
    end
  end

  // A delivery is held until the next delivery or the end of the scan so the last one of a scan can be marked.
  logic pend_out, last_out;
  always_comb begin
    hold_v_nxt = 1'b0;
    pend_out = 1'b0;
    last_out = 1'b0;
    if (act) begin
      hold_v_nxt = hit ? 1'b1 : (hold_v_r && !fin);
      if (hit) hold_v_nxt = 1'b1;
      else if (fin) hold_v_nxt = 1'b0;
      else hold_v_nxt = hold_v_r;
      pend_out = hold_v_r && hit;
      last_out = 1'b0;
    end
    if (!act && hold_v_r) begin
      pend_out = 1'b1; last_out = 1'b1;
    end
    if (act && fin && hold_v_r && !hit) begin
      pend_out = 1'b1; last_out = 1'b1;
    end
  end

  always_comb begin
    out_valid = rdv_r || pend_out;
    out_result_kind = rdv_r ? KIND_READ : hold_kind_r;
    out_read_data = rdv_r ? rd_r : 32'd0;
    out_int_vector = rdv_r ? 8'd0 : hold_vec_r;
    out_delivery_mode = rdv_r ? 3'd0 : hold_dm_r;
    out_trigger_mode = rdv_r ? 1'b0 : hold_trig_r;
    out_last = rdv_r || last_out;
  end

  `IRC_ASSERT_IMPL(a_no_overlap, clk, rst_n, !(rdv_r && pend_out), "read and delivery collide")
  `IRC_ASSERT_NEXT(a_read_strobe, clk, rst_n, go && in_req_type == REQ_READ, out_valid && out_last, "read not answered")
  `IRC_ASSERT_IMPL(a_busy_scan, clk, rst_n, !act || busy, "scan while idle")
endmodule
